// ===== rtl/core/spf_pkg.sv =====
package spf_pkg;

  // Register file size and index widths
  localparam int FP_REG_COUNT = 32;
  localparam int REG_AW = (FP_REG_COUNT > 1) ? $clog2(FP_REG_COUNT) : 1;
  localparam int IDX_W = 5;

  // Binary32 bit patterns
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
  localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

  // Operation codes of the command beat
  typedef enum logic [3:0] {
    K_ADD   = 4'd0,
    K_SUB   = 4'd1,
    K_MUL   = 4'd2,
    K_DIV   = 4'd3,
    K_SQRT  = 4'd4,
    K_SGNJ  = 4'd5,
    K_SGNJN = 4'd6,
    K_SGNJX = 4'd7,
    K_MIN   = 4'd8,
    K_MAX   = 4'd9,
    K_LOAD  = 4'd10
  } kind_t;

  // Operations handled by the shared arithmetic unit
  typedef enum logic [2:0] {
    AOP_ADD,
    AOP_SUB,
    AOP_MUL,
    AOP_DIV,
    AOP_SQRT
  } aop_t;

  typedef struct packed {
    logic        start;
    aop_t        op;
    logic [31:0] a;
    logic [31:0] b;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } arith_rsp_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_RDA,
    T_RDB,
    T_EXEC,
    T_WAIT,
    T_WB
  } top_state_t;

  typedef enum logic [3:0] {
    A_IDLE,
    A_MUL,
    A_NRMA,
    A_NRMB,
    A_DIV,
    A_SQRT,
    A_NORM,
    A_RND,
    A_OUT
  } ar_state_t;

  function automatic logic is_nan(input logic [31:0] x);
    logic res;
    res = (x & MAG_MASK) > INF_BITS;
    return res;
  endfunction

endpackage

// ===== rtl/core/spf_ram.sv =====
module spf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/spf_arith.sv =====
module spf_arith
  import spf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  localparam int MW = 48;
  localparam int EW = 11;

  ar_state_t state_r, state_nxt;
  logic                 sgn_r, sgn_nxt;
  logic signed [EW-1:0] e_r, e_nxt;
  logic [MW-1:0]        m_r, m_nxt;
  logic [23:0]          ma_r, ma_nxt, mb_r, mb_nxt;
  logic signed [EW-1:0] ea_r, ea_nxt, eb_r, eb_nxt;
  logic [26:0]          rem_r, rem_nxt;
  logic [51:0]          v_r, v_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic                 sq_r, sq_nxt;
  logic [31:0]          res_r, res_nxt;

  // Operand unpack
  logic [31:0]          a, b;
  logic signed [EW-1:0] ua_e, ub_e;
  logic [23:0]          ua_m, ub_m;
  logic nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
  logic sx, sbe, eff_sub, a_big, mag_eq, add_sgn;

  always_comb begin
    a = req.a;
    b = req.b;
    ua_e = (a[30:23] == 8'd0) ? EW'(1) : $signed({3'b000, a[30:23]});
    ub_e = (b[30:23] == 8'd0) ? EW'(1) : $signed({3'b000, b[30:23]});
    ua_m = {a[30:23] != 8'd0, a[22:0]};
    ub_m = {b[30:23] != 8'd0, b[22:0]};
    nan_a = is_nan(a);
    nan_b = is_nan(b);
    inf_a = (a[30:0] == INF_BITS[30:0]);
    inf_b = (b[30:0] == INF_BITS[30:0]);
    zer_a = (a[30:0] == 31'd0);
    zer_b = (b[30:0] == 31'd0);
    sx = a[31] ^ b[31];
    sbe = b[31] ^ (req.op == AOP_SUB);
    eff_sub = a[31] ^ sbe;
    a_big = (a[30:0] >= b[30:0]);
    mag_eq = (a[30:0] == b[30:0]);
    add_sgn = (eff_sub && mag_eq) ? 1'b0 : (a_big ? a[31] : sbe);
  end

  // Add alignment: shift the smaller significand, jam lost bits into bit 0
  logic signed [EW-1:0] e_big, e_sml, e_dif;
  logic [MW-1:0] m_big48, m_sml48, m_sh, m_lost, m_sum;
  logic          st_al;

  always_comb begin
    e_big = a_big ? ua_e : ub_e;
    e_sml = a_big ? ub_e : ua_e;
    e_dif = e_big - e_sml;
    m_big48 = {1'b0, (a_big ? ua_m : ub_m), 23'd0};
    m_sml48 = {1'b0, (a_big ? ub_m : ua_m), 23'd0};
    if (e_dif >= EW'(MW)) begin
      m_sh = '0;
      m_lost = m_sml48;
    end else begin
      m_sh = m_sml48 >> e_dif[5:0];
      m_lost = m_sml48 & ((MW'(1) << e_dif[5:0]) - MW'(1));
    end
    st_al = |m_lost;
    m_sum = eff_sub ? (m_big48 - (m_sh | MW'(st_al))) : (m_big48 + (m_sh | MW'(st_al)));
  end

  // Shared compare/subtract step for divide and square root
  logic [28:0] op_x, op_y, op_dif, op_sel;
  logic        op_ge;

  always_comb begin
    if (sq_r) begin
      op_x = {rem_r, v_r[51:50]};
      op_y = {1'b0, m_r[25:0], 2'b01};
    end else begin
      op_x = {4'd0, rem_r[24:0]};
      op_y = {5'd0, mb_r};
    end
    op_ge = (op_x >= op_y);
    op_dif = op_x - op_y;
    op_sel = op_ge ? op_dif : op_x;
  end

  // Round to nearest even and pack
  logic [23:0]          pk_frac;
  logic                 pk_inc;
  logic [24:0]          pk_r25;
  logic signed [EW-1:0] pk_e;
  logic [31:0]          pk_res;
  logic signed [EW-1:0] sq_e;

  always_comb begin
    pk_frac = m_r[47:24];
    pk_inc = m_r[23] & ((|m_r[22:0]) | pk_frac[0]);
    pk_r25 = {1'b0, pk_frac} + 25'(pk_inc);
    pk_e = pk_r25[24] ? (e_r + EW'(1)) : e_r;
    if (!pk_r25[24] && !pk_r25[23]) begin
      pk_res = {sgn_r, 8'd0, pk_r25[22:0]};
    end else if (pk_e >= EW'(255)) begin
      pk_res = {sgn_r, INF_BITS[30:0]};
    end else begin
      pk_res = {sgn_r, pk_e[7:0], pk_r25[22:0]};
    end
    sq_e = (ea_r + EW'(127)) >>> 1;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    sgn_nxt = sgn_r;
    e_nxt = e_r;
    m_nxt = m_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    ea_nxt = ea_r;
    eb_nxt = eb_r;
    rem_nxt = rem_r;
    v_nxt = v_r;
    cnt_nxt = cnt_r;
    sq_nxt = sq_r;
    res_nxt = res_r;
    rsp.done = 1'b0;
    rsp.res = res_r;
    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          state_nxt = A_OUT;
          ma_nxt = ua_m;
          mb_nxt = ub_m;
          ea_nxt = ua_e;
          eb_nxt = ub_e;
          sgn_nxt = sx;
          sq_nxt = 1'b0;
          case (req.op)
            AOP_ADD, AOP_SUB: begin
              if (nan_a || nan_b) begin
                res_nxt = CANON_NAN;
              end else if (inf_a && inf_b) begin
                res_nxt = eff_sub ? CANON_NAN : a;
              end else if (inf_a) begin
                res_nxt = a;
              end else if (inf_b) begin
                res_nxt = {sbe, b[30:0]};
              end else begin
                m_nxt = m_sum;
                e_nxt = e_big + EW'(1);
                sgn_nxt = add_sgn;
                state_nxt = A_NORM;
              end
            end
            AOP_MUL: begin
              if (nan_a || nan_b || (inf_a && zer_b) || (zer_a && inf_b)) begin
                res_nxt = CANON_NAN;
              end else if (inf_a || inf_b) begin
                res_nxt = {sx, INF_BITS[30:0]};
              end else begin
                e_nxt = ua_e + ub_e - EW'(126);
                state_nxt = A_MUL;
              end
            end
            AOP_DIV: begin
              if (zer_b) begin
                res_nxt = (nan_a || zer_a) ? CANON_NAN : {sx, INF_BITS[30:0]};
              end else if (nan_a || nan_b || (inf_a && inf_b)) begin
                res_nxt = CANON_NAN;
              end else if (inf_a) begin
                res_nxt = {sx, INF_BITS[30:0]};
              end else if (inf_b || zer_a) begin
                res_nxt = {sx, 31'd0};
              end else begin
                state_nxt = A_NRMA;
              end
            end
            AOP_SQRT: begin
              if (nan_a) begin
                res_nxt = CANON_NAN;
              end else if (zer_a) begin
                res_nxt = a;
              end else if (a[31]) begin
                res_nxt = CANON_NAN;
              end else if (inf_a) begin
                res_nxt = a;
              end else begin
                sgn_nxt = 1'b0;
                sq_nxt = 1'b1;
                state_nxt = A_NRMA;
              end
            end
            default: begin
              res_nxt = CANON_NAN;
            end
          endcase
        end
      end
      A_MUL: begin
        m_nxt = ma_r * mb_r;
        state_nxt = A_NORM;
      end
      A_NRMA: begin
        if (ma_r[23]) begin
          if (sq_r) begin
            // odd exponent: radicand doubled
            v_nxt = {(ea_r[0] ? {1'b0, ma_r} : {ma_r, 1'b0}), 27'd0};
            e_nxt = sq_e;
            rem_nxt = '0;
            m_nxt = '0;
            cnt_nxt = 6'd25;
            state_nxt = A_SQRT;
          end else begin
            state_nxt = A_NRMB;
          end
        end else begin
          ma_nxt = {ma_r[22:0], 1'b0};
          ea_nxt = ea_r - EW'(1);
        end
      end
      A_NRMB: begin
        if (mb_r[23]) begin
          rem_nxt = {3'd0, ma_r};
          m_nxt = '0;
          cnt_nxt = 6'd47;
          e_nxt = ea_r - eb_r + EW'(127);
          state_nxt = A_DIV;
        end else begin
          mb_nxt = {mb_r[22:0], 1'b0};
          eb_nxt = eb_r - EW'(1);
        end
      end
      A_DIV: begin
        rem_nxt = {op_sel[25:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          m_nxt = {m_r[46:0], op_ge | (op_sel != 29'd0)};
          state_nxt = A_NORM;
        end else begin
          m_nxt = {m_r[46:0], op_ge};
        end
      end
      A_SQRT: begin
        rem_nxt = op_sel[26:0];
        v_nxt = {v_r[49:0], 2'b00};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          m_nxt = {m_r[24:0], op_ge, 21'd0, op_sel != 29'd0};
          state_nxt = A_NORM;
        end else begin
          m_nxt = {m_r[46:0], op_ge};
        end
      end
      A_NORM: begin
        if ((m_r != '0) && !m_r[47] && (e_r > EW'(1))) begin
          m_nxt = {m_r[46:0], 1'b0};
          e_nxt = e_r - EW'(1);
        end else if (e_r < EW'(1)) begin
          // deep underflow collapses to a sticky bit
          if (e_r < -EW'(60)) begin
            m_nxt = {47'd0, |m_r};
            e_nxt = EW'(1);
          end else begin
            m_nxt = {1'b0, m_r[47:2], m_r[1] | m_r[0]};
            e_nxt = e_r + EW'(1);
          end
        end else begin
          state_nxt = A_RND;
        end
      end
      A_RND: begin
        res_nxt = pk_res;
        state_nxt = A_OUT;
      end
      A_OUT: begin
        rsp.done = 1'b1;
        state_nxt = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sgn_r <= sgn_nxt;
    e_r <= e_nxt;
    m_r <= m_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    ea_r <= ea_nxt;
    eb_r <= eb_nxt;
    rem_r <= rem_nxt;
    v_r <= v_nxt;
    cnt_r <= cnt_nxt;
    sq_r <= sq_nxt;
    res_r <= res_nxt;
  end

endmodule

// ===== rtl/core/single_precision_fpu_with_register_file_core.sv =====
// Single-precision FPU with a floating-point register file.
// Command channel: a beat is taken when start is high and busy is low; it
// carries the operation kind, destination and source register indices and
// the raw value for a load. busy stays high until the result beat is out.
// Result channel: out_valid is high for exactly one cycle with the result
// value, the echoed destination index and the illegal flag; the receiver
// cannot stall, so the beat is gone after that cycle.
// Sequencing: the two source registers are read one after the other through the
// single read port of the register file RAM. Sign injection, min, max, load
// and illegal kinds are computed in the execute state itself. Add and subtract
// go through the shared arithmetic unit (alignment, one normalize step per
// cycle, rounding); infinity and NaN operands skip the normalize and rounding
// steps, and multiply adds a product step. Divide runs 48 quotient steps and
// square root 26 root steps on the same compare/subtract unit, plus the
// operand and result normalize shifts.
// A new command is taken the cycle after the result beat.
// Reset clears every register to zero through per-entry valid bits; no
// clearing pass is needed and a command may be issued right after reset.
module single_precision_fpu_with_register_file_core
  import spf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [3:0]       in_kind,
  input  logic [IDX_W-1:0] in_dest_reg,
  input  logic [IDX_W-1:0] in_src1_reg,
  input  logic [IDX_W-1:0] in_src2_reg,
  input  logic [31:0]      in_load_value,
  output logic             out_valid,
  output logic [31:0]      out_result_value,
  output logic [IDX_W-1:0] out_result_reg,
  output logic             out_illegal
);

  top_state_t state_r, state_nxt;
  logic [3:0]             kind_r;
  logic [IDX_W-1:0]       dest_r, src1_r, src2_r;
  logic [31:0]            load_r, a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic                   ill_r, ill_nxt;
  logic [FP_REG_COUNT-1:0] vld_r;
  logic [REG_AW-1:0]      raddr;
  logic [31:0]            rdata;
  logic                   src1_ok, src2_ok, dest_ok, we;
  arith_req_t             areq;
  arith_rsp_t             arsp;

  spf_ram #(.WIDTH(32), .DEPTH(FP_REG_COUNT)) u_rf (
    .clk  (clk),
    .we   (we),
    .waddr(dest_r[REG_AW-1:0]),
    .wdata(res_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  spf_arith u_arith (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (areq),
    .rsp  (arsp)
  );

  // Total order key for min/max, -0 below +0
  function automatic logic [31:0] order_key(input logic [31:0] x);
    logic [31:0] k;
    k = x[31] ? ~x : (x | SIGN_MASK);
    return k;
  endfunction

  function automatic logic [31:0] min_max(input logic [31:0] x, input logic [31:0] y,
                                          input logic want_max);
    logic [31:0] r;
    logic        xn, yn;
    xn = is_nan(x);
    yn = is_nan(y);
    if (xn && yn) begin
      r = CANON_NAN;
    end else if (xn) begin
      r = y;
    end else if (yn) begin
      r = x;
    end else if (want_max) begin
      r = (order_key(x) >= order_key(y)) ? x : y;
    end else begin
      r = (order_key(x) <= order_key(y)) ? x : y;
    end
    return r;
  endfunction

  assign src1_ok = {1'b0, src1_r} < (IDX_W + 1)'(FP_REG_COUNT);
  assign src2_ok = {1'b0, src2_r} < (IDX_W + 1)'(FP_REG_COUNT);
  assign dest_ok = {1'b0, dest_r} < (IDX_W + 1)'(FP_REG_COUNT);

  // First source address goes out with the command beat
  assign raddr = (state_r == T_IDLE) ? in_src1_reg[REG_AW-1:0] : src2_r[REG_AW-1:0];

  assign busy = (state_r != T_IDLE);
  assign out_valid = (state_r == T_WB);
  assign out_result_value = res_r;
  assign out_result_reg = dest_r;
  assign out_illegal = ill_r;
  assign we = (state_r == T_WB) && !ill_r && dest_ok;

  // Command sequencer
  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r;
    b_nxt = b_r;
    res_nxt = res_r;
    ill_nxt = ill_r;
    areq.start = 1'b0;
    areq.op = AOP_ADD;
    areq.a = a_r;
    areq.b = b_r;
    unique case (state_r)
      T_IDLE: begin
        if (start) begin
          state_nxt = T_RDA;
        end
      end
      T_RDA: begin
        a_nxt = (src1_ok && vld_r[src1_r[REG_AW-1:0]]) ? rdata : 32'd0;
        state_nxt = T_RDB;
      end
      T_RDB: begin
        b_nxt = (src2_ok && vld_r[src2_r[REG_AW-1:0]]) ? rdata : 32'd0;
        state_nxt = T_EXEC;
      end
      T_EXEC: begin
        ill_nxt = 1'b0;
        state_nxt = T_WB;
        unique case (kind_t'(kind_r))
          K_ADD: begin
            areq.start = 1'b1;
            areq.op = AOP_ADD;
            state_nxt = T_WAIT;
          end
          K_SUB: begin
            areq.start = 1'b1;
            areq.op = AOP_SUB;
            state_nxt = T_WAIT;
          end
          K_MUL: begin
            areq.start = 1'b1;
            areq.op = AOP_MUL;
            state_nxt = T_WAIT;
          end
          K_DIV: begin
            areq.start = 1'b1;
            areq.op = AOP_DIV;
            state_nxt = T_WAIT;
          end
          K_SQRT: begin
            areq.start = 1'b1;
            areq.op = AOP_SQRT;
            state_nxt = T_WAIT;
          end
          K_SGNJ:  res_nxt = {b_r[31], a_r[30:0]};
          K_SGNJN: res_nxt = {~b_r[31], a_r[30:0]};
          K_SGNJX: res_nxt = {a_r[31] ^ b_r[31], a_r[30:0]};
          K_MIN:   res_nxt = min_max(a_r, b_r, 1'b0);
          K_MAX:   res_nxt = min_max(a_r, b_r, 1'b1);
          K_LOAD:  res_nxt = load_r;
          default: begin
            res_nxt = 32'd0;
            ill_nxt = 1'b1;
          end
        endcase
      end
      T_WAIT: begin
        if (arsp.done) begin
          res_nxt = arsp.res;
          state_nxt = T_WB;
        end
      end
      T_WB: begin
        state_nxt = T_IDLE;
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (we) begin
        vld_r[dest_r[REG_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Command capture and operand/result registers
  always_ff @(posedge clk) begin
    if (state_r == T_IDLE && start) begin
      kind_r <= in_kind;
      dest_r <= in_dest_reg;
      src1_r <= in_src1_reg;
      src2_r <= in_src2_reg;
      load_r <= in_load_value;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    res_r <= res_nxt;
    ill_r <= ill_nxt;
  end

endmodule

// ===== rtl/core/spf_chk.sv =====
module spf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_result_value,
  input logic        out_illegal
);

  // A taken command beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after command beat");

  // Result beat only while a command is in flight
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");

  // One result beat per command, then ready again
  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result beat not followed by idle");

  // Illegal commands report a zero value
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |-> out_result_value == 32'd0)
    else $error("illegal beat with nonzero value");

endmodule

bind single_precision_fpu_with_register_file_core spf_chk u_spf_chk (.*);
